// ----- rtl/core/bil_pkg.sv -----
// Package with the beat types, codes and constants of the bounded integer list engine.
package bil_pkg;

    localparam int unsigned DEPTH_DEFAULT = 64;
    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned POS_W         = 6;
    localparam int unsigned ENTRY_CNT_W   = 7;

    typedef enum logic [1:0] {
        OP_APPEND   = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_READ     = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_NOTFOUND = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_BADPOS   = 3'd4
    } status_t;

    typedef struct packed {
        opcode_t                     opcode;
        logic signed [VALUE_W-1:0]   value;
        logic        [POS_W-1:0]     position;
    } cmd_beat_t;

    typedef struct packed {
        status_t                       status;
        logic                          found;
        logic signed [VALUE_W-1:0]     read_value;
        logic        [ENTRY_CNT_W-1:0] entry_count;
    } rsp_beat_t;

    typedef struct packed {
        logic                      cmp_en;
        logic                      commit;
        opcode_t                   opcode;
        logic signed [VALUE_W-1:0] value;
        logic        [POS_W-1:0]   position;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/bil_cell.sv -----
// One list cell: holds a single entry, compares it, shifts it down and forwards read data.
module bil_cell
    import bil_pkg::*;
#(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CNT_W = 7
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cell_ctrl_t                ctrl,
    input  logic        [CNT_W-1:0]   count,
    input  logic signed [VALUE_W-1:0] next_entry,
    input  logic                      hit_in,
    input  logic signed [VALUE_W-1:0] rd_in,
    output logic signed [VALUE_W-1:0] entry,
    output logic                      hit_out,
    output logic signed [VALUE_W-1:0] rd_out
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      match_reg;
    logic                      match_next;
    logic                      sel;

    assign match_next = (IDX < count) && (entry_reg == ctrl.value);
    assign hit_out    = hit_in | match_reg;
    assign entry      = entry_reg;

    generate
        if (INDEX < (1 << POS_W))
        begin : g_reach
            assign sel = (ctrl.position == POS_W'(INDEX));
        end
        else
        begin : g_noreach
            assign sel = 1'b0;
        end
    endgenerate

    assign rd_out = sel ? entry_reg : rd_in;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.commit)
        begin
            unique case (ctrl.opcode)
                OP_APPEND:
                begin
                    if (IDX == count)
                    begin
                        entry_next = ctrl.value;
                    end
                end
                OP_REMOVE:
                begin
                    if (hit_out)
                    begin
                        entry_next = next_entry;
                    end
                end
                OP_CONTAINS: ;
                OP_READ: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/core/bounded_int_list_engine.sv -----
// Top level of the bounded integer list engine: control, entry count and the row of cells.
//
//  channel  dir  handshake            payload
//  cmd      in   cmd_valid/cmd_stall  cmd_beat_t: opcode, value, position
//  rsp      out  rsp_valid/rsp_stall  rsp_beat_t: status, found, read_value, entry_count
//
// Every operation passes through S_CMP, in which all cells compare their entry in
// parallel, and S_DONE, in which the first-match chain across the cells settles and the
// entries shift, the count updates and the result is registered.
// A new beat is taken in the cycle the previous result is registered, so a new beat
// goes from S_DONE straight into S_CMP while the response side keeps up.
// Reset clears the count and control state; entries hold no reset value.
// A stalled response holds the block in S_DONE until the register frees.
module bounded_int_list_engine
    import bil_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_beat_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    cmd_beat_t                 cmd_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      rsp_valid_reg;
    rsp_beat_t                 rsp_reg;
    rsp_beat_t                 rsp_next;
    logic                      rsp_free;
    logic                      commit;
    logic                      cmd_accept;
    cell_ctrl_t                ctrl;
    logic                      hit [DEPTH+1];
    logic signed [VALUE_W-1:0] rd [DEPTH+1];
    logic signed [VALUE_W-1:0] entries [DEPTH];

    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign commit     = (state_reg == S_DONE) && rsp_free;
    assign cmd_stall  = !((state_reg == S_IDLE) || commit);
    assign cmd_accept = cmd_valid && !cmd_stall;

    assign ctrl.cmp_en   = (state_reg == S_CMP);
    assign ctrl.commit   = commit;
    assign ctrl.opcode   = cmd_reg.opcode;
    assign ctrl.value    = cmd_reg.value;
    assign ctrl.position = cmd_reg.position;

    assign hit[0] = 1'b0;
    assign rd[0]  = '0;

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic signed [VALUE_W-1:0] nxt;
            if (i + 1 < DEPTH)
            begin : g_mid
                assign nxt = entries[i+1];
            end
            else
            begin : g_last
                assign nxt = entries[i];
            end

            bil_cell #(
                .INDEX (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .count      (count_reg),
                .next_entry (nxt),
                .hit_in     (hit[i]),
                .rd_in      (rd[i]),
                .entry      (entries[i]),
                .hit_out    (hit[i+1]),
                .rd_out     (rd[i+1])
            );
        end
    endgenerate

    always_comb
    begin
        count_next          = count_reg;
        rsp_next.status     = STAT_OK;
        rsp_next.found      = 1'b0;
        rsp_next.read_value = '0;
        unique case (cmd_reg.opcode)
            OP_APPEND:
            begin
                if (count_reg == FULL_CNT)
                begin
                    rsp_next.status = STAT_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    rsp_next.status = STAT_EMPTY;
                end
                else if (!hit[DEPTH])
                begin
                    rsp_next.status = STAT_NOTFOUND;
                end
                else
                begin
                    count_next     = count_reg - 1'b1;
                    rsp_next.found = 1'b1;
                end
            end
            OP_CONTAINS:
            begin
                if (count_reg == '0)
                begin
                    rsp_next.status = STAT_EMPTY;
                end
                else if (!hit[DEPTH])
                begin
                    rsp_next.status = STAT_NOTFOUND;
                end
                else
                begin
                    rsp_next.found = 1'b1;
                end
            end
            OP_READ:
            begin
                if (count_reg == '0)
                begin
                    rsp_next.status = STAT_EMPTY;
                end
                else if (CMP_W'(cmd_reg.position) >= CMP_W'(count_reg))
                begin
                    rsp_next.status = STAT_BADPOS;
                end
                else
                begin
                    rsp_next.read_value = rd[DEPTH];
                end
            end
        endcase
        rsp_next.entry_count = ENTRY_CNT_W'(count_next);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (commit)
                begin
                    state_next = cmd_accept ? S_CMP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            cmd_reg <= cmd;
        end
        if (commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count exceeds the store depth");

    a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> (state_reg == S_CMP))
        else $error("accepted beat did not start a compare cycle");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside the final cycle");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.found) |-> (rsp_reg.status == STAT_OK))
        else $error("found flag set with an error status");

endmodule
